// ===== rtl/crcchk_pkg.sv =====
package crcchk_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;
  localparam int          WIN_LEN  = 6;

  localparam logic [7:0] TRL_C    = 8'h43;
  localparam logic [7:0] TRL_R    = 8'h52;
  localparam logic [7:0] TRL_MARK = 8'h10;

  localparam logic [2:0] FILL_FULL = 3'd6;
  localparam logic [2:0] FILL_LAST = 3'd5;

  typedef struct packed {
    logic        crc_match;
    logic [15:0] received_crc;
    logic        trailer_found;
    logic [15:0] computed_crc;
  } result_t;

  // CRC-16 with polynomial 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((r & CRC_TOP) != 16'h0000) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/crcchk_track.sv =====
module crcchk_track import crcchk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output result_t     result
);

  logic [15:0] crc_all;
  logic [15:0] crc_lag;
  logic [7:0]  window [WIN_LEN];
  logic [2:0]  fill;

  logic [15:0] crc_all_next;
  logic [15:0] crc_lag_next;
  logic [2:0]  fill_next;
  logic        found;

  always_comb begin
    crc_all_next = crc_byte(crc_all, data_byte);
    crc_lag_next = (fill == FILL_FULL) ? crc_byte(crc_lag, window[0]) : crc_lag;
    fill_next    = (fill == FILL_FULL) ? fill : fill + 3'd1;
  end

  // after the shift the window oldest-first is window[1..5], data_byte
  always_comb begin
    found = (fill >= FILL_LAST) &&
            (window[1] == TRL_C) && (window[2] == TRL_R) &&
            (window[3] == TRL_C) && (window[4] == TRL_MARK);
    result.trailer_found = found;
    result.computed_crc  = found ? crc_lag_next : crc_all_next;
    result.received_crc  = found ? {data_byte, window[5]} : 16'h0000;
    result.crc_match     = found && (crc_lag_next == {data_byte, window[5]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_all <= 16'h0000;
      crc_lag <= 16'h0000;
      fill    <= 3'd0;
    end else if (accept) begin
      if (last) begin
        // start the next image from clean state
        crc_all <= 16'h0000;
        crc_lag <= 16'h0000;
        fill    <= 3'd0;
      end else begin
        crc_all <= crc_all_next;
        crc_lag <= crc_lag_next;
        fill    <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        window[i] <= window[i + 1];
      end
      window[WIN_LEN - 1] <= data_byte;
    end
  end

endmodule

// ===== rtl/crcchk_out_reg.sv =====
module crcchk_out_reg import crcchk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  input  logic    ready,
  output logic    valid,
  output result_t data
);

  logic valid_next;

  always_comb begin
    priority if (load) begin
      valid_next = 1'b1;
    end else if (ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// ===== rtl/crc16_image_check_with_trailer_unit.sv =====
// Streams an image one byte per item and, on the item with tlast, delivers one result:
// the CRC-16/XMODEM of the image, the trailer flag ('C','R','C',0x10 followed by a stored
// CRC low byte first in the last six bytes), the stored CRC (zero without a trailer) and
// a match flag. When a trailer is found the computed CRC excludes those six bytes; images
// shorter than six bytes never carry one. One byte is accepted every cycle: both CRCs
// advance by a full byte step for each accepted byte and the result sits in an output register,
// so input stalls only while a finished result is held by m_tready low. State clears
// after each last byte, so images follow back to back.
module crc16_image_check_with_trailer_unit import crcchk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [15:0] computed_crc, [16] trailer_found,
                                 // [32:17] received_crc, [33] crc_match, [39:34] zero
);

  logic    accept;
  result_t track_result;
  result_t out_result;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  crcchk_track u_track (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last      (s_tlast),
    .result    (track_result)
  );

  crcchk_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && s_tlast),
    .load_data (track_result),
    .ready     (m_tready),
    .valid     (m_tvalid),
    .data      (out_result)
  );

  assign m_tdata = {6'b000000, out_result.crc_match, out_result.received_crc,
                    out_result.trailer_found, out_result.computed_crc};

  a_rise_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result appeared without a last item");

  a_no_result_mid_image: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tlast && !m_tvalid) |=> !m_tvalid)
    else $error("result produced for an item without last");

  a_match_needs_trailer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> m_tdata[16] && (m_tdata[15:0] == m_tdata[32:17]))
    else $error("crc_match without trailer or equal CRCs");

  a_no_trailer_zero_rx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[16] |-> (m_tdata[32:17] == 16'h0000))
    else $error("received_crc nonzero without trailer");

endmodule
